// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands shared by the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define RCT_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, off while reset is high
`define RCT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

// next-cycle implication that also covers reset
`define RCT_ASSERT_ALWAYS(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

`endif

// ===== src/rct_pkg.sv =====
// ----------------------------------------------------------------------------
// rct_pkg
// shared types and constants of the refinement cell tagger
// ----------------------------------------------------------------------------
package rct_pkg;

  typedef enum logic [2:0] {
    REG_MODE_FLAGS    = 3'd0,
    REG_GRID_ORIGIN   = 3'd1,
    REG_CELL_SIZE     = 3'd2,
    REG_INV_TWO_SIZE  = 3'd3,
    REG_SPHERE_CENTER = 3'd4,
    REG_REGION_LOW    = 3'd5,
    REG_REGION_HIGH   = 3'd6,
    REG_THRESHOLDS    = 3'd7
  } rct_reg_t;

  localparam int MODE_ENABLE   = 0;
  localparam int MODE_SOURCE   = 1;
  localparam int MODE_POROSITY = 2;
  localparam int MODE_BOX      = 3;

  localparam logic [47:0] CELL_SIZE_RESET = 48'h0100_0100_0100;
  localparam logic [47:0] INV_TWO_RESET   = 48'h0080_0080_0080;
  localparam logic [17:0] ONE_Q15         = 18'd32768;

  typedef struct packed {
    logic [3:0]  mode_flags;
    logic [47:0] grid_origin;
    logic [47:0] cell_size;
    logic [47:0] inv_two_size;
    logic [47:0] sphere_center;
    logic [47:0] region_low;
    logic [47:0] region_high;
    logic [47:0] thresholds;
  } rct_cfg_t;

  typedef struct packed {
    logic [7:0]  cell_i;
    logic [7:0]  cell_j;
    logic [7:0]  cell_k;
    logic [15:0] leak_center;
    logic [31:0] leak_pair_x;
    logic [31:0] leak_pair_y;
    logic [31:0] leak_pair_z;
    logic [15:0] porosity_center;
    logic [31:0] porosity_pair_x;
    logic [31:0] porosity_pair_y;
    logic [31:0] porosity_pair_z;
  } rct_cell_t;

  typedef struct packed {
    logic gradient_tag;
    logic region_tag;
    logic poro_tag;
    logic refine_tag;
  } rct_tags_t;

  function automatic logic [15:0] lane16(input logic [47:0] p, input int unsigned n);
    return p[n*16 +: 16];
  endfunction

endpackage

// ===== src/rct_cell_if.sv =====
// ----------------------------------------------------------------------------
// rct_cell_if
// valid/ready channel carrying one grid cell and its face neighbours
// ----------------------------------------------------------------------------
interface rct_cell_if import rct_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [7:0]  cell_i;
  logic [7:0]  cell_j;
  logic [7:0]  cell_k;
  logic [15:0] leak_center;
  logic [31:0] leak_pair_x;
  logic [31:0] leak_pair_y;
  logic [31:0] leak_pair_z;
  logic [15:0] porosity_center;
  logic [31:0] porosity_pair_x;
  logic [31:0] porosity_pair_y;
  logic [31:0] porosity_pair_z;

  modport source (
    output valid, cell_i, cell_j, cell_k, leak_center, leak_pair_x, leak_pair_y,
           leak_pair_z, porosity_center, porosity_pair_x, porosity_pair_y,
           porosity_pair_z,
    input  ready
  );
  modport sink (
    input  valid, cell_i, cell_j, cell_k, leak_center, leak_pair_x, leak_pair_y,
           leak_pair_z, porosity_center, porosity_pair_x, porosity_pair_y,
           porosity_pair_z,
    output ready
  );
endinterface

// ===== src/rct_tag_if.sv =====
// ----------------------------------------------------------------------------
// rct_tag_if
// valid/ready channel carrying the four refinement tags of one cell
// ----------------------------------------------------------------------------
interface rct_tag_if import rct_pkg::*; ();
  logic valid;
  logic ready;
  logic gradient_tag;
  logic region_tag;
  logic poro_tag;
  logic refine_tag;

  modport source (
    output valid, gradient_tag, region_tag, poro_tag, refine_tag,
    input  ready
  );
  modport sink (
    input  valid, gradient_tag, region_tag, poro_tag, refine_tag,
    output ready
  );
endinterface

// ===== src/rct_cfg.sv =====
// ----------------------------------------------------------------------------
// rct_cfg
// configuration register file, write only
// ----------------------------------------------------------------------------
module rct_cfg import rct_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        we,
  input  logic [2:0]  index,
  input  logic [47:0] data,
  output rct_cfg_t    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode_flags    <= '0;
      cfg.grid_origin   <= '0;
      cfg.cell_size     <= CELL_SIZE_RESET;
      cfg.inv_two_size  <= INV_TWO_RESET;
      cfg.sphere_center <= '0;
      cfg.region_low    <= '0;
      cfg.region_high   <= '0;
      cfg.thresholds    <= '0;
    end else if (we) begin
      case (rct_reg_t'(index))
        REG_MODE_FLAGS:    cfg.mode_flags    <= data[3:0];
        REG_GRID_ORIGIN:   cfg.grid_origin   <= data;
        REG_CELL_SIZE:     cfg.cell_size     <= data;
        REG_INV_TWO_SIZE:  cfg.inv_two_size  <= data;
        REG_SPHERE_CENTER: cfg.sphere_center <= data;
        REG_REGION_LOW:    cfg.region_low    <= data;
        REG_REGION_HIGH:   cfg.region_high   <= data;
        REG_THRESHOLDS:    cfg.thresholds    <= data;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/rct_pipe.sv =====
// ----------------------------------------------------------------------------
// rct_pipe
// four-stage tagging datapath: stencil, products, squares, compare
// ----------------------------------------------------------------------------
module rct_pipe import rct_pkg::*; #(
  parameter int GRID_X = 256,
  parameter int GRID_Y = 256,
  parameter int GRID_Z = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  rct_cfg_t  cfg,
  input  logic      in_valid,
  output logic      in_ready,
  input  rct_cell_t cell_data,
  output logic      out_valid,
  input  logic      out_ready,
  output rct_tags_t tags
);

  localparam logic [35:0] LAST_ALL = {12'(GRID_Z - 1), 12'(GRID_Y - 1), 12'(GRID_X - 1)};

  logic en;
  logic v1, v2, v3, v4;

  // whole pipe moves together; an empty output slot always frees it
  assign en        = !v4 || out_ready;
  assign in_ready  = en;
  assign out_valid = v4;

  // stage 1: face substitution, differences, porosity test, centre position
  logic [7:0]         idx      [3];
  logic [31:0]        lpair    [3];
  logic [31:0]        ppair    [3];
  logic [15:0]        ym       [3];
  logic [15:0]        yp       [3];
  logic [15:0]        pm       [3];
  logic [15:0]        pp       [3];
  logic [15:0]        dm       [3];
  logic [15:0]        dp       [3];
  logic [24:0]        odd_mul  [3];
  logic [15:0]        gdiff_n  [3];
  logic signed [27:0] pos_n    [3];
  logic [15:0]        jump;
  logic [15:0]        pt;
  logic               transition;
  logic               por_n;

  logic [15:0]        s1_gdiff [3];
  logic signed [27:0] s1_pos   [3];
  logic               s1_por;

  always_comb begin
    idx[0]   = cell_data.cell_i;
    idx[1]   = cell_data.cell_j;
    idx[2]   = cell_data.cell_k;
    lpair[0] = cell_data.leak_pair_x;
    lpair[1] = cell_data.leak_pair_y;
    lpair[2] = cell_data.leak_pair_z;
    ppair[0] = cell_data.porosity_pair_x;
    ppair[1] = cell_data.porosity_pair_y;
    ppair[2] = cell_data.porosity_pair_z;
    jump     = '0;
    for (int a = 0; a < 3; a++) begin
      ym[a] = lpair[a][15:0];
      yp[a] = lpair[a][31:16];
      pm[a] = ppair[a][15:0];
      pp[a] = ppair[a][31:16];
      if (idx[a] == 8'd0) begin
        ym[a] = cell_data.leak_center;
        pm[a] = cell_data.porosity_center;
      end
      if ({4'b0, idx[a]} >= LAST_ALL[a*12 +: 12]) begin
        yp[a] = cell_data.leak_center;
        pp[a] = cell_data.porosity_center;
      end
      gdiff_n[a] = (yp[a] >= ym[a]) ? yp[a] - ym[a] : ym[a] - yp[a];
      dm[a] = (cell_data.porosity_center >= pm[a]) ? cell_data.porosity_center - pm[a]
                                                   : pm[a] - cell_data.porosity_center;
      dp[a] = (cell_data.porosity_center >= pp[a]) ? cell_data.porosity_center - pp[a]
                                                   : pp[a] - cell_data.porosity_center;
      if (dm[a] > jump) jump = dm[a];
      if (dp[a] > jump) jump = dp[a];
      // doubled centre: 2*origin + (2*idx+1)*size
      odd_mul[a] = 25'({idx[a], 1'b1}) * 25'(lane16(cfg.cell_size, a));
      pos_n[a] = $signed({{11{cfg.grid_origin[a*16+15]}},
                          lane16(cfg.grid_origin, a), 1'b0})
               + $signed({3'b0, odd_mul[a]});
    end
    pt = lane16(cfg.thresholds, 0);
    transition = (cell_data.porosity_center > pt) &&
                 ($signed({2'b0, cell_data.porosity_center}) <
                  $signed(ONE_Q15) - $signed({2'b0, pt}));
    por_n = cfg.mode_flags[MODE_POROSITY] && ((jump >= pt) || transition);
  end

  // stage 2: gradient magnitudes, sphere offsets, box test
  logic [31:0]        s2_mag [3];
  logic signed [27:0] s2_d   [3];
  logic               s2_box;
  logic               s2_por;
  logic               box_n;
  logic signed [27:0] lo2    [3];
  logic signed [27:0] hi2    [3];
  logic signed [27:0] c2     [3];

  always_comb begin
    box_n = 1'b1;
    for (int a = 0; a < 3; a++) begin
      lo2[a] = $signed({{11{cfg.region_low[a*16+15]}},
                        lane16(cfg.region_low, a), 1'b0});
      hi2[a] = $signed({{11{cfg.region_high[a*16+15]}},
                        lane16(cfg.region_high, a), 1'b0});
      c2[a]  = $signed({{11{cfg.sphere_center[a*16+15]}},
                        lane16(cfg.sphere_center, a), 1'b0});
      if (s1_pos[a] < lo2[a] || s1_pos[a] > hi2[a]) box_n = 1'b0;
    end
  end

  // stage 3: squares
  logic [63:0]        s3_sq  [3];
  logic [55:0]        s3_dsq [3];
  logic [31:0]        s3_thr2;
  logic [31:0]        s3_rad2;
  logic               s3_box;
  logic               s3_por;
  logic signed [55:0] dprod  [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dprod[a] = s2_d[a] * s2_d[a];
    end
  end

  // stage 4: sums, compares, mode gating
  logic [65:0] gsum;
  logic [65:0] gthr;
  logic [57:0] dsum;
  logic [57:0] rthr;
  logic        grad_n;
  logic        src_n;
  logic        por_g;
  logic        enable;

  always_comb begin
    gsum   = 66'(s3_sq[0]) + 66'(s3_sq[1]) + 66'(s3_sq[2]);
    gthr   = {4'b0, s3_thr2, 30'b0};
    dsum   = 58'(s3_dsq[0]) + 58'(s3_dsq[1]) + 58'(s3_dsq[2]);
    rthr   = {24'b0, s3_rad2, 2'b0};
    enable = cfg.mode_flags[MODE_ENABLE];
    grad_n = enable && (gsum >= gthr);
    src_n  = enable && cfg.mode_flags[MODE_SOURCE] &&
             (cfg.mode_flags[MODE_BOX] ? s3_box : (dsum <= rthr));
    por_g  = enable && s3_por;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        s1_gdiff[a] <= gdiff_n[a];
        s1_pos[a]   <= pos_n[a];
        s2_mag[a]   <= 32'(s1_gdiff[a]) * 32'(lane16(cfg.inv_two_size, a));
        s2_d[a]     <= s1_pos[a] - c2[a];
        s3_sq[a]    <= 64'(s2_mag[a]) * 64'(s2_mag[a]);
        s3_dsq[a]   <= unsigned'(dprod[a]);
      end
      s1_por  <= por_n;
      s2_por  <= s1_por;
      s2_box  <= box_n;
      s3_por  <= s2_por;
      s3_box  <= s2_box;
      s3_thr2 <= 32'(lane16(cfg.thresholds, 1)) * 32'(lane16(cfg.thresholds, 1));
      s3_rad2 <= 32'(lane16(cfg.thresholds, 2)) * 32'(lane16(cfg.thresholds, 2));
      tags.gradient_tag <= grad_n;
      tags.region_tag   <= src_n;
      tags.poro_tag     <= por_g;
      tags.refine_tag   <= grad_n || src_n || por_g;
    end
  end

endmodule

// ===== src/refinement_cell_tagger_core.sv =====
// throughput: one cell per cycle; the four stages advance together and
// hold only while the output register is full and not taken
// reset: synchronous, clears all stage valid bits and loads the register
// defaults (tagging off, unit cell size, half inverse size)
// ----------------------------------------------------------------------------
// refinement_cell_tagger_core
// per-cell gradient, source region and porosity refinement tagging
// ----------------------------------------------------------------------------
module refinement_cell_tagger_core import rct_pkg::*; #(
  parameter int GRID_X = 256,
  parameter int GRID_Y = 256,
  parameter int GRID_Z = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  rct_cell_if.sink    cell_in,
  rct_tag_if.source   tag_out
);

  rct_cfg_t  cfg;
  rct_cell_t cell_data;
  rct_tags_t tags;

  assign cell_data.cell_i          = cell_in.cell_i;
  assign cell_data.cell_j          = cell_in.cell_j;
  assign cell_data.cell_k          = cell_in.cell_k;
  assign cell_data.leak_center     = cell_in.leak_center;
  assign cell_data.leak_pair_x     = cell_in.leak_pair_x;
  assign cell_data.leak_pair_y     = cell_in.leak_pair_y;
  assign cell_data.leak_pair_z     = cell_in.leak_pair_z;
  assign cell_data.porosity_center = cell_in.porosity_center;
  assign cell_data.porosity_pair_x = cell_in.porosity_pair_x;
  assign cell_data.porosity_pair_y = cell_in.porosity_pair_y;
  assign cell_data.porosity_pair_z = cell_in.porosity_pair_z;

  rct_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  rct_pipe #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y),
    .GRID_Z (GRID_Z)
  ) u_pipe (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (cell_in.valid),
    .in_ready  (cell_in.ready),
    .cell_data (cell_data),
    .out_valid (tag_out.valid),
    .out_ready (tag_out.ready),
    .tags      (tags)
  );

  assign tag_out.gradient_tag = tags.gradient_tag;
  assign tag_out.region_tag   = tags.region_tag;
  assign tag_out.poro_tag     = tags.poro_tag;
  assign tag_out.refine_tag   = tags.refine_tag;

endmodule

// ===== src/rct_checker.sv =====
// ----------------------------------------------------------------------------
// rct_checker
// port-level checks of the tagger, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rct_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic gradient_tag,
  input logic region_tag,
  input logic poro_tag,
  input logic refine_tag
);

  logic [3:0] tag_bits;
  logic       any_tag;

  assign tag_bits = {gradient_tag, region_tag, poro_tag, refine_tag};
  assign any_tag  = gradient_tag || region_tag || poro_tag;

  `RCT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(tag_bits), "stalled tag transaction changed")
  `RCT_ASSERT_NOW(a_refine_or, out_valid, refine_tag == any_tag, "refine tag is not the or of the others")
  `RCT_ASSERT_NOW(a_ready_stall, !in_ready, out_valid && !out_ready, "input stalled with free output")
  `RCT_ASSERT_ALWAYS(a_reset_empty, rst, !out_valid, "output valid right after reset")

endmodule

bind refinement_cell_tagger_core rct_checker u_rct_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (cell_in.valid),
  .in_ready     (cell_in.ready),
  .out_valid    (tag_out.valid),
  .out_ready    (tag_out.ready),
  .gradient_tag (tag_out.gradient_tag),
  .region_tag   (tag_out.region_tag),
  .poro_tag     (tag_out.poro_tag),
  .refine_tag   (tag_out.refine_tag)
);

// ===== test/refinement_cell_tagger_core_tb.sv =====
// ----------------------------------------------------------------------------
// refinement_cell_tagger_core_tb
// Drives grid cells through the tagger under several register settings and
// compares every tag transaction with given tags or a built-in tag predictor.
// Both channel sides idle at random, one long output stall fills the pipeline,
// and input pauses let the pipeline drain completely.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module refinement_cell_tagger_core_tb import rct_pkg::*; ();

  localparam int GRID_LAST = 255;
  localparam int LIMIT = 400000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [47:0] cfg_data;

  rct_cell_if cell_ch ();
  rct_tag_if tag_ch ();

  refinement_cell_tagger_core u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cell_in(cell_ch.sink), .tag_out(tag_ch.source)
  );

  rct_cfg_t regs;
  rct_tags_t tag_queue[$];
  int errors;
  int cycles;
  bit long_stall;
  bit stall_done;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic logic signed [17:0] s16(input logic [47:0] p, input int n);
    return $signed(p[n*16 +: 16]);
  endfunction

  function automatic rct_tags_t tag_cell(input rct_cell_t c);
    rct_tags_t t;
    logic [7:0] idx[3];
    logic [31:0] lp[3], pp[3];
    longint yc, pc, ym, yp, pm, pq, jump, pt, r2, rad2, d;
    longint pos2[3];
    logic [127:0] sum, thr;
    logic [63:0] mag;
    bit in_box;
    t = '0;
    if (!regs.mode_flags[MODE_ENABLE]) return t;
    idx = '{c.cell_i, c.cell_j, c.cell_k};
    lp = '{c.leak_pair_x, c.leak_pair_y, c.leak_pair_z};
    pp = '{c.porosity_pair_x, c.porosity_pair_y, c.porosity_pair_z};
    yc = c.leak_center;
    pc = c.porosity_center;
    sum = 0;
    jump = 0;
    for (int a = 0; a < 3; a++) begin
      ym = lp[a][15:0]; yp = lp[a][31:16];
      pm = pp[a][15:0]; pq = pp[a][31:16];
      if (idx[a] == 0) begin ym = yc; pm = pc; end
      if (idx[a] >= GRID_LAST) begin yp = yc; pq = pc; end
      mag = ((yp > ym) ? yp - ym : ym - yp) * longint'(regs.inv_two_size[a*16 +: 16]);
      sum += 128'(mag) * 128'(mag);
      if (((pc > pm) ? pc - pm : pm - pc) > jump) jump = (pc > pm) ? pc - pm : pm - pc;
      if (((pc > pq) ? pc - pq : pq - pc) > jump) jump = (pc > pq) ? pc - pq : pq - pc;
      pos2[a] = 2 * longint'(s16(regs.grid_origin, a))
              + (2 * longint'(idx[a]) + 1) * longint'(regs.cell_size[a*16 +: 16]);
    end
    thr = 128'(regs.thresholds[31:16]) << 15;
    t.gradient_tag = sum >= thr * thr;
    if (regs.mode_flags[MODE_SOURCE]) begin
      if (regs.mode_flags[MODE_BOX]) begin
        in_box = 1;
        for (int a = 0; a < 3; a++)
          if (pos2[a] < 2 * longint'(s16(regs.region_low, a)) ||
              pos2[a] > 2 * longint'(s16(regs.region_high, a))) in_box = 0;
        t.region_tag = in_box;
      end else begin
        r2 = 0;
        rad2 = 2 * longint'(regs.thresholds[47:32]);
        for (int a = 0; a < 3; a++) begin
          d = pos2[a] - 2 * longint'(s16(regs.sphere_center, a));
          r2 += d * d;
        end
        t.region_tag = r2 <= rad2 * rad2;
      end
    end
    if (regs.mode_flags[MODE_POROSITY]) begin
      pt = regs.thresholds[15:0];
      t.poro_tag = jump >= pt || (pc > pt && pc < longint'(ONE_Q15) - pt);
    end
    t.refine_tag = t.gradient_tag | t.region_tag | t.poro_tag;
    return t;
  endfunction

  // each write drops the enable again before the next one, which keeps the enable edges apart
  task automatic write_reg(input rct_reg_t r, input logic [47:0] v);
    cfg_we <= 1; cfg_index <= r; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    case (r)
      REG_MODE_FLAGS:    regs.mode_flags = v[3:0];
      REG_GRID_ORIGIN:   regs.grid_origin = v;
      REG_CELL_SIZE:     regs.cell_size = v;
      REG_INV_TWO_SIZE:  regs.inv_two_size = v;
      REG_SPHERE_CENTER: regs.sphere_center = v;
      REG_REGION_LOW:    regs.region_low = v;
      REG_REGION_HIGH:   regs.region_high = v;
      REG_THRESHOLDS:    regs.thresholds = v;
      default: ;
    endcase
  endtask

  task automatic drain();
    cell_ch.valid <= 0;
    while (tag_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // send one cell; the expectation is pushed when the transaction happens
  // valid stays high between back-to-back cells unless a random idle gap is drawn
  task automatic send_cell(input rct_cell_t c, input bit use_given, input rct_tags_t given);
    if ($urandom_range(0, 3) == 0) begin
      cell_ch.valid <= 0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3))
        @(posedge clk);
    end
    cell_ch.valid <= 1;
    {cell_ch.cell_i, cell_ch.cell_j, cell_ch.cell_k, cell_ch.leak_center,
     cell_ch.leak_pair_x, cell_ch.leak_pair_y, cell_ch.leak_pair_z,
     cell_ch.porosity_center, cell_ch.porosity_pair_x, cell_ch.porosity_pair_y,
     cell_ch.porosity_pair_z} <= c;
    do @(posedge clk); while (!cell_ch.ready);
    tag_queue.push_back(use_given ? given : tag_cell(c));
  endtask

  function automatic logic [15:0] frac();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'hffff;
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic rct_cell_t rand_cell();
    rct_cell_t c;
    logic [7:0] ix[3];
    for (int a = 0; a < 3; a++)
      case ($urandom_range(0, 5))
        0: ix[a] = 8'd0;
        1: ix[a] = 8'd255;
        2: ix[a] = 8'd254;
        default: ix[a] = 8'($urandom_range(0, 255));
      endcase
    c.cell_i = ix[0]; c.cell_j = ix[1]; c.cell_k = ix[2];
    c.leak_center = frac();
    c.porosity_center = frac();
    if ($urandom_range(0, 1)) begin
      c.leak_pair_x = $urandom; c.leak_pair_y = $urandom; c.leak_pair_z = $urandom;
      c.porosity_pair_x = $urandom; c.porosity_pair_y = $urandom;
      c.porosity_pair_z = $urandom;
    end else begin
      c.leak_pair_x = {frac(), frac()}; c.leak_pair_y = {frac(), frac()};
      c.leak_pair_z = {frac(), frac()};
      c.porosity_pair_x = {frac(), frac()}; c.porosity_pair_y = {frac(), frac()};
      c.porosity_pair_z = {frac(), frac()};
    end
    return c;
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // output side: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      tag_ch.ready <= 0;
    end else if (long_stall && !stall_done) begin
      tag_ch.ready <= 0;
    end else begin
      tag_ch.ready <= ($urandom_range(0, 3) != 0);
    end
    if (!rst && tag_ch.valid && tag_ch.ready) begin
      if (tag_queue.size() == 0) begin
        report("unexpected transaction", 1, 0);
      end else begin
        automatic rct_tags_t w = tag_queue.pop_front();
        if (tag_ch.gradient_tag !== w.gradient_tag)
          report("gradient_tag", tag_ch.gradient_tag, w.gradient_tag);
        if (tag_ch.region_tag !== w.region_tag)
          report("region_tag", tag_ch.region_tag, w.region_tag);
        if (tag_ch.poro_tag !== w.poro_tag)
          report("poro_tag", tag_ch.poro_tag, w.poro_tag);
        if (tag_ch.refine_tag !== w.refine_tag)
          report("refine_tag", tag_ch.refine_tag, w.refine_tag);
      end
    end
  end

  initial begin
    long_stall = 0;
    stall_done = 0;
    wait (long_stall);
    repeat (200) @(posedge clk);
    stall_done = 1;
  end

  typedef struct {
    rct_cell_t c;
    bit typed;
    rct_tags_t t;
  } cell_row_t;

  cell_row_t rows[$];
  rct_cell_t z;

  initial begin
    errors = 0;
    cycles = 0;
    rst = 1;
    cfg_we = 0; cfg_index = REG_MODE_FLAGS; cfg_data = '0;
    cell_ch.valid = 0;
    {cell_ch.cell_i, cell_ch.cell_j, cell_ch.cell_k, cell_ch.leak_center,
     cell_ch.leak_pair_x, cell_ch.leak_pair_y, cell_ch.leak_pair_z,
     cell_ch.porosity_center, cell_ch.porosity_pair_x, cell_ch.porosity_pair_y,
     cell_ch.porosity_pair_z} = '0;
    regs = '0;
    regs.cell_size = CELL_SIZE_RESET;
    regs.inv_two_size = INV_TWO_RESET;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // after reset tagging is off: all tags zero
    z = '0;
    rows.push_back('{z, 1, 4'b0000});
    z = '1;
    rows.push_back('{z, 1, 4'b0000});
    foreach (rows[n]) send_cell(rows[n].c, rows[n].typed, rows[n].t);
    drain();

    // enabled with zero threshold: gradient always set
    write_reg(REG_MODE_FLAGS, 48'hf1);
    rows.delete();
    z = '0;
    rows.push_back('{z, 1, 4'b1001});
    z = '1;
    rows.push_back('{z, 1, 4'b1001});
    foreach (rows[n]) send_cell(rows[n].c, rows[n].typed, rows[n].t);
    drain();

    // all features, box source, directed extremes through the predictor
    write_reg(REG_THRESHOLDS, {16'h0400, 16'h0010, 16'h1000});
    write_reg(REG_REGION_LOW, {16'hff00, 16'hff00, 16'hff00});
    write_reg(REG_REGION_HIGH, {16'h0800, 16'h0800, 16'h0800});
    write_reg(REG_MODE_FLAGS, 48'hf);
    rows.delete();
    z = '0; z.cell_i = 8'd255; z.cell_j = 8'd254; z.leak_center = 16'h8000;
    rows.push_back('{z, 0, '0});
    z.porosity_center = 16'h4000;
    rows.push_back('{z, 0, '0});
    z = '0; z.leak_pair_x = 32'h8000_0000; z.porosity_pair_y = 32'hffff_0000;
    z.cell_i = 8'd5; z.cell_j = 8'd7; z.cell_k = 8'd3;
    rows.push_back('{z, 0, '0});
    z.leak_pair_z = 32'hffff_0000; z.leak_center = 16'hffff;
    rows.push_back('{z, 0, '0});
    z = '1;
    rows.push_back('{z, 0, '0});
    foreach (rows[n]) send_cell(rows[n].c, rows[n].typed, rows[n].t);
    drain();

    // sphere source
    write_reg(REG_SPHERE_CENTER, {16'h0400, 16'h0400, 16'h0400});
    write_reg(REG_MODE_FLAGS, 48'h7);
    for (int n = 0; n < 8; n++) send_cell(rand_cell(), 0, '0);
    drain();

    // random phases, each with fresh register settings
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_MODE_FLAGS, ph == 0 ? 48'h0 : 48'($urandom_range(0, 255)) | 48'h1);
      write_reg(REG_GRID_ORIGIN, ph == 1 ? '1 : ph == 2 ? 48'h7fff_8000_7fff : rand48());
      write_reg(REG_CELL_SIZE, ph == 1 ? '1 : ph == 2 ? '0 :
                {16'($urandom_range(1, 1024)), 16'($urandom_range(1, 1024)),
                 16'($urandom_range(1, 1024))});
      write_reg(REG_INV_TWO_SIZE, ph == 1 ? '1 : ph == 2 ? '0 : rand48());
      write_reg(REG_SPHERE_CENTER, rand48());
      write_reg(REG_REGION_LOW, ph == 3 ? 48'h8000_8000_8000 : rand48());
      write_reg(REG_REGION_HIGH, ph == 3 ? 48'h7fff_7fff_7fff : rand48());
      write_reg(REG_THRESHOLDS, ph == 1 ? '1 :
                {16'($urandom), 16'($urandom_range(0, 16'hffff)),
                 16'($urandom_range(0, 16'h9000))});
      if (ph == 4) long_stall = 1;
      for (int n = 0; n < 130; n++) begin
        send_cell(rand_cell(), 0, '0);
        // wait for the pipeline to empty once mid-phase
        if (ph == 6 && n == 60) drain();
      end
      drain();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
